>>> sv/lct_pkg.sv
// lct_pkg: shared constants, request codes and memory port type for the
// linked chain table. No dependencies.
package lct_pkg;

    // Table geometry: nodes 1..NODES, entry 0 means "none"
    localparam int NODES  = 64;
    localparam int NODE_W = 7;
    localparam int CNT_W  = $clog2(NODES);

    // Request codes
    localparam logic [1:0] KIND_LINK   = 2'd0;
    localparam logic [1:0] KIND_UNLINK = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;

    // One read port and one write port of a link memory
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [NODE_W-1:0] wr_data;
    } mem_req_t;

endpackage

>>> sv/lct_link_mem.sv
// lct_link_mem: one link table (NODES+1 entries), registered read, one write.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on lct_pkg.
module lct_link_mem
    import lct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          req,
    output logic [NODE_W-1:0] rd_data
);

    logic [NODE_W-1:0] mem [0:NODES];
    logic [NODES:0]    valid_reg;
    logic [NODE_W-1:0] rd_data_reg;

    // Storage write
    always_ff @(posedge clk)
    begin
        if (req.wr_en && req.wr_addr <= NODE_W'(NODES))
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Valid bits: cleared at reset, set on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en && req.wr_addr <= NODE_W'(NODES))
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Registered read; unwritten entries give "none"
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            if (req.rd_addr <= NODE_W'(NODES) && valid_reg[req.rd_addr])
            begin
                rd_data_reg <= mem[req.rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/lct_ctrl.sv
// lct_ctrl: request sequencer. Applies link/unlink writes, walks back to the
// chain head, then walks forward emitting one result per node.
// Depends on lct_pkg.
module lct_ctrl
    import lct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  logic [NODE_W-1:0] car_a,
    input  logic [NODE_W-1:0] car_b,
    input  logic [NODE_W-1:0] prev_rd,
    input  logic [NODE_W-1:0] next_rd,
    output logic              busy,
    output mem_req_t          prev_req,
    output mem_req_t          next_req,
    output logic              strobe,
    output logic [NODE_W-1:0] car,
    output logic              last_of_run
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BACK = 2'd1;
    localparam logic [1:0] ST_FWD  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              strobe_reg, strobe_next;
    logic [NODE_W-1:0] car_reg, car_next;
    logic              last_reg, last_next;

    logic a_ok, b_ok, p_ok, nx_end, fwd_last;
    logic [CNT_W:0] steps_plus2;

    assign a_ok        = car_a <= NODE_W'(NODES);
    assign b_ok        = car_b <= NODE_W'(NODES);
    assign p_ok        = prev_rd != '0 && prev_rd <= NODE_W'(NODES);
    assign nx_end      = next_rd == '0 || next_rd > NODE_W'(NODES);
    assign fwd_last    = nx_end || count_reg == CNT_W'(NODES - 1);
    assign steps_plus2 = {1'b0, steps_reg} + (CNT_W+1)'(2);

    // Next-state and memory request logic
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        steps_next  = steps_reg;
        count_next  = count_reg;
        strobe_next = 1'b0;
        car_next    = car_reg;
        last_next   = last_reg;
        prev_req    = '0;
        next_req    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_LINK, KIND_UNLINK:
                        begin
                            if (a_ok && b_ok)
                            begin
                                next_req.wr_en   = car_a != '0;
                                next_req.wr_addr = car_a;
                                next_req.wr_data = (kind == KIND_LINK) ? car_b : '0;
                                prev_req.wr_en   = car_b != '0;
                                prev_req.wr_addr = car_b;
                                prev_req.wr_data = (kind == KIND_LINK) ? car_a : '0;
                            end
                        end
                        KIND_LIST:
                        begin
                            if (car_a != '0 && a_ok)
                            begin
                                prev_req.rd_en   = 1'b1;
                                prev_req.rd_addr = car_a;
                                cur_next         = car_a;
                                steps_next       = '0;
                                state_next       = ST_BACK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // One backward step per cycle; read address follows read data
            ST_BACK:
            begin
                if (p_ok)
                begin
                    cur_next   = prev_rd;
                    steps_next = steps_reg + CNT_W'(1);
                    if (steps_plus2 < (CNT_W+1)'(NODES))
                    begin
                        prev_req.rd_en   = 1'b1;
                        prev_req.rd_addr = prev_rd;
                    end
                    else
                    begin
                        next_req.rd_en   = 1'b1;
                        next_req.rd_addr = prev_rd;
                        count_next       = '0;
                        state_next       = ST_FWD;
                    end
                end
                else
                begin
                    next_req.rd_en   = 1'b1;
                    next_req.rd_addr = cur_reg;
                    count_next       = '0;
                    state_next       = ST_FWD;
                end
            end

            // One result per cycle on the forward walk
            ST_FWD:
            begin
                strobe_next = 1'b1;
                car_next    = cur_reg;
                last_next   = fwd_last;
                if (fwd_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next         = next_rd;
                    count_next       = count_reg + CNT_W'(1);
                    next_req.rd_en   = 1'b1;
                    next_req.rd_addr = next_rd;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Walk and result payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        count_reg <= count_next;
        car_reg   <= car_next;
        last_reg  <= last_next;
    end

    assign busy        = state_reg != ST_IDLE;
    assign strobe      = strobe_reg;
    assign car         = car_reg;
    assign last_of_run = last_reg;

endmodule

>>> sv/linked_chain_table.sv
// linked_chain_table: top level of the doubly linked node table.
// Depends on lct_pkg, lct_link_mem, lct_ctrl.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------
//   request  | start, busy        | kind, car_a, car_b
//   result   | strobe (one cycle) | car, last_of_run
//
// Link and unlink write the link memories directly from idle; busy stays low and
// the next request may follow at once. A list request holds busy for each backward
// step (up to NODES-1), through one more check unless the step cap ends the walk,
// and for each emitted node (up to NODES); the walk is paced by the registered read
// of the prev and next link memories. Each result is strobed in the cycle after
// its walk cycle, so the last one shows in the first idle cycle.
// Reset clears both tables through per-entry valid bits, with no sweep.
// Results cannot be stalled; each is shown for one cycle on strobe.
module linked_chain_table
    import lct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        kind,
    input  logic [NODE_W-1:0] car_a,
    input  logic [NODE_W-1:0] car_b,
    output logic              strobe,
    output logic [NODE_W-1:0] car,
    output logic              last_of_run
);

    mem_req_t          prev_req, next_req;
    logic [NODE_W-1:0] prev_rd, next_rd;

    // Predecessor links
    lct_link_mem u_prev_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (prev_req),
        .rd_data (prev_rd)
    );

    // Successor links
    lct_link_mem u_next_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (next_req),
        .rd_data (next_rd)
    );

    // Request sequencer
    lct_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .car_a       (car_a),
        .car_b       (car_b),
        .prev_rd     (prev_rd),
        .next_rd     (next_rd),
        .busy        (busy),
        .prev_req    (prev_req),
        .next_req    (next_req),
        .strobe      (strobe),
        .car         (car),
        .last_of_run (last_of_run)
    );

endmodule
